// ===== rtl/core/jos_pkg.sv =====
package jos_pkg;

    // Ring capacity and derived index width
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);

    // Field widths of the words on the channels
    localparam int SIZE_W  = 7;
    localparam int STEP_W  = 10;
    localparam int LABEL_W = 7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch a new problem
        logic build_wr;  // write one ring link
        logic prime;     // reload step counter after the build
        logic advance;   // move one entry along the ring
        logic remove;    // unlink the current entry and emit it
        logic finish;    // emit the survivor
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic build_done;
        logic cnt_zero;
        logic rem_one;
        logic rem_two;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/jos_if.sv =====
interface jos_in_if;
    import jos_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIZE_W-1:0]  circle_size;
    logic [SIZE_W-1:0]  start_position;
    logic [STEP_W-1:0]  step_count;

    modport source (output valid, circle_size, start_position, step_count, input ready);
    modport sink   (input valid, circle_size, start_position, step_count, output ready);
endinterface

interface jos_out_if;
    import jos_pkg::*;

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] removed_label;
    logic               last_of_run;

    modport source (output valid, removed_label, last_of_run, input ready);
    modport sink   (input valid, removed_label, last_of_run, output ready);
endinterface

// ===== rtl/core/jos_dp.sv =====
module jos_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  jos_pkg::t_dp_cmd        i_cmd,
    output jos_pkg::t_dp_status     o_status,
    input  logic [jos_pkg::SIZE_W-1:0]  i_circle_size,
    input  logic [jos_pkg::SIZE_W-1:0]  i_start_position,
    input  logic [jos_pkg::STEP_W-1:0]  i_step_count,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [jos_pkg::LABEL_W-1:0] o_removed_label,
    output logic                    o_last_of_run
);
    import jos_pkg::*;

    // Successor links, one per ring entry
    logic [IDX_W-1:0]   mem [MAX_ENTRIES];
    logic [IDX_W-1:0]   r_q;

    logic [SIZE_W-1:0]  r_size;
    logic [STEP_W-1:0]  r_step;
    logic [IDX_W-1:0]   r_cur;
    logic [IDX_W-1:0]   r_prev;
    logic [IDX_W-1:0]   r_idx;
    logic [SIZE_W-1:0]  r_rem;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_label;
    logic               r_last;

    logic [SIZE_W-1:0]  sat_size;
    logic [SIZE_W-1:0]  sat_start;
    logic [STEP_W-1:0]  sat_step;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   n_cur;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   wr_data;
    logic               out_free;

    // Clamp the incoming problem to legal values
    always_comb begin
        if (i_circle_size == '0) begin
            sat_size = SIZE_W'(1);
        end else if (i_circle_size > SIZE_W'(MAX_ENTRIES)) begin
            sat_size = SIZE_W'(MAX_ENTRIES);
        end else begin
            sat_size = i_circle_size;
        end
        if (i_start_position == '0) begin
            sat_start = SIZE_W'(1);
        end else if (i_start_position > sat_size) begin
            sat_start = sat_size;
        end else begin
            sat_start = i_start_position;
        end
        sat_step = (i_step_count == '0) ? STEP_W'(1) : i_step_count;
    end

    assign last_idx = IDX_W'(r_size - SIZE_W'(1));
    assign out_free = !r_out_valid || i_out_ready;

    // Pick the next current entry; the read port follows it
    always_comb begin
        if (i_cmd.load) begin
            n_cur = IDX_W'(sat_start - SIZE_W'(1));
        end else if (i_cmd.advance || i_cmd.remove) begin
            n_cur = r_q;
        end else begin
            n_cur = r_cur;
        end
    end

    // Share the write port between ring build and unlink
    always_comb begin
        wr_en = i_cmd.build_wr || i_cmd.remove;
        if (i_cmd.build_wr) begin
            wr_addr = r_idx;
            wr_data = (r_idx == last_idx) ? '0 : r_idx + IDX_W'(1);
        end else begin
            wr_addr = r_prev;
            wr_data = r_q;
        end
    end

    // Successor memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_q <= mem[n_cur];
    end

    // Ring walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_prev <= '0;
            r_rem  <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
            r_size <= '0;
            r_step <= '0;
        end else begin
            r_cur <= n_cur;
            if (i_cmd.load) begin
                r_size <= sat_size;
                r_step <= sat_step;
                r_rem  <= sat_size;
                r_idx  <= '0;
                r_prev <= (sat_start == SIZE_W'(1)) ? IDX_W'(sat_size - SIZE_W'(1))
                                                    : IDX_W'(sat_start - SIZE_W'(2));
            end
            if (i_cmd.build_wr) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.advance) begin
                r_prev <= r_cur;
                r_cnt  <= r_cnt - STEP_W'(1);
            end
            if (i_cmd.prime || i_cmd.remove) begin
                r_cnt <= r_step - STEP_W'(1);
            end
            if (i_cmd.remove) begin
                r_rem <= r_rem - SIZE_W'(1);
            end
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.remove || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.remove || i_cmd.finish) begin
            r_label <= LABEL_W'(r_cur) + LABEL_W'(1);
            r_last  <= i_cmd.finish;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_label = r_label;
    assign o_last_of_run   = r_last;

    assign o_status.build_done = (r_idx == last_idx);
    assign o_status.cnt_zero   = (r_cnt == '0);
    assign o_status.rem_one    = (r_rem == SIZE_W'(1));
    assign o_status.rem_two    = (r_rem == SIZE_W'(2));
    assign o_status.out_free   = out_free;

endmodule

// ===== rtl/core/jos_ctrl.sv =====
module jos_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jos_pkg::t_dp_status i_status,
    output jos_pkg::t_dp_cmd    o_cmd
);
    import jos_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BUILD  = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Sequence one problem: build, prime, walk and remove, emit survivor
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BUILD;
                end
            end
            ST_BUILD: begin
                o_cmd.build_wr = 1'b1;
                if (i_status.build_done) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state = i_status.rem_one ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                if (!i_status.cnt_zero) begin
                    o_cmd.advance = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.remove = 1'b1;
                    if (i_status.rem_two) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/josephus_elimination_order.sv =====
// Josephus elimination order.
// Input channel i_item carries one problem per word: circle_size,
// start_position and step_count. Output channel o_result carries one word
// per removed label, in removal order, and then the survivor with
// last_of_run set. Size and start are clamped to 1..64 and 1..size, a step
// of zero acts as one.
// Per problem the block writes the size successor links of the ring into
// its 64-entry link memory, primes the memory read, then for each of the
// size-1 removals walks step_count-1 links, one link per cycle, and
// unlinks and emits the current entry; last it emits the survivor.
// One problem is in work at a time; i_item.ready is high only between
// problems.
// Reset clears the controller and the output register; the link memory
// needs no clearing since every problem writes its links before reading.
// When the receiver stalls, the output word holds and the walk pauses at
// the next removal; a new problem may be accepted while the survivor word
// still waits in the output register.
module josephus_elimination_order (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jos_in_if.sink      i_item,
    jos_out_if.source   o_result
);
    import jos_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    jos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jos_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_circle_size    (i_item.circle_size),
        .i_start_position (i_item.start_position),
        .i_step_count     (i_item.step_count),
        .o_out_valid      (o_result.valid),
        .i_out_ready      (o_result.ready),
        .o_removed_label  (o_result.removed_label),
        .o_last_of_run    (o_result.last_of_run)
    );

endmodule
